/* rtl/smcsc_pkg.sv */
// ----------------------------------------------------------------------------
// smcsc_pkg
// Shared types and constants for the compressed-sparse-column matrix store.
// ----------------------------------------------------------------------------
package smcsc_pkg;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned NROWS_W    = 13;
  localparam int unsigned NCOLS_W    = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned S_TDATA_W  = 56;
  localparam int unsigned M_TDATA_W  = 32;

  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 13'd4096;
  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 1'b0,
    CFG_NUM_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_RD_LO,
    S_RD_HI,
    S_RD_TOT,
    S_SCAN,
    S_SCAN_CMP,
    S_DECIDE,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DEL_WR,
    S_PTR_RD,
    S_PTR_WR,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PA_COL,
    PA_COL1,
    PA_TOT,
    PA_SWEEP
  } ptr_ra_e;

  typedef enum logic [1:0] {
    PD_ZERO,
    PD_INC,
    PD_DEC
  } ptr_wd_e;

  typedef enum logic [1:0] {
    EA_K,
    EA_KM1,
    EA_KP1
  } ent_ra_e;

  typedef enum logic [1:0] {
    EW_K,
    EW_POS,
    EW_HI
  } ent_wa_e;

  typedef enum logic {
    ED_NEW,
    ED_MOVE
  } ent_wd_e;

  typedef struct packed {
    logic    in_cap;
    logic    lo_cap;
    logic    hi_cap;
    logic    tot_cap;
    logic    hit_cap;
    logic    k_ld_tot;
    logic    k_ld_pos;
    logic    k_inc;
    logic    k_dec;
    logic    c_ld_col1;
    logic    c_inc;
    ptr_ra_e ptr_ra;
    logic    ptr_we;
    ptr_wd_e ptr_wd;
    ent_ra_e ent_ra;
    logic    ent_we;
    ent_wa_e ent_wa;
    ent_wd_e ent_wd;
    logic    out_ld;
    stat_e   out_st;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic func;
    logic nv_zero;
    logic found;
    logic full;
    logic k_lt_hi;
    logic hit;
    logic ins_more;
    logic del_more;
    logic c_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/smcsc_ram.sv */
// ----------------------------------------------------------------------------
// smcsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smcsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/smcsc_dp.sv */
// ----------------------------------------------------------------------------
// smcsc_dp
// Datapath: config registers, column pointer and entry memories, scan and
// shift counters, result register.
// ----------------------------------------------------------------------------
module smcsc_dp
  import smcsc_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_NONZERO = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_func_i,
  input  logic [ROW_W-1:0]      in_row_i,
  input  logic [COL_W-1:0]      in_col_i,
  input  logic [DATA_W-1:0]     in_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_W-1:0]     out_value_o,
  output logic [STATUS_W-1:0]   out_status_o,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o
);

  localparam int unsigned PW  = $clog2(MAX_NONZERO + 1);
  localparam int unsigned EAW = $clog2(MAX_NONZERO);
  localparam int unsigned PAW = $clog2(MAX_COLS + 1);
  localparam int unsigned EW  = ROW_W + VALUE_WIDTH;

  logic [NROWS_W-1:0]     num_rows_q;
  logic [NCOLS_W-1:0]     num_cols_q;
  logic                   func_q;
  logic [ROW_W-1:0]       row_q;
  logic [COL_W-1:0]       col_q;
  logic [VALUE_WIDTH-1:0] nv_q;
  logic [VALUE_WIDTH-1:0] old_q;
  logic                   found_q;
  logic [PW-1:0]          lo_q, hi_q, tot_q, k_q, pos_q;
  logic [PAW-1:0]         c_q;
  logic                   out_valid_q;
  logic [DATA_W-1:0]      out_value_q;
  logic [STATUS_W-1:0]    out_status_q;

  logic [PW-1:0]          ptr_rdata, ptr_wdata, tot_clip, k_m1, k_p1;
  logic [PAW-1:0]         ptr_raddr, col_p1;
  logic [EW-1:0]          ent_rdata, ent_wdata;
  logic [EAW-1:0]         ent_raddr, ent_waddr;
  logic [VALUE_WIDTH-1:0] nv_norm;

  // sign-extend or truncate the incoming word to the stored width
  assign nv_norm = VALUE_WIDTH'(signed'(in_value_i));
  assign col_p1  = PAW'(col_q) + 1'b1;
  assign k_m1    = k_q - 1'b1;
  assign k_p1    = k_q + 1'b1;
  assign tot_clip = (32'(ptr_rdata) > MAX_NONZERO) ? PW'(MAX_NONZERO) : ptr_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NUM_ROWS_RST;
      num_cols_q <= NUM_COLS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_ROWS) begin
        num_rows_q <= cfg_data_i[NROWS_W-1:0];
      end else begin
        num_cols_q <= cfg_data_i[NCOLS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_cap) begin
      func_q  <= in_func_i;
      row_q   <= in_row_i;
      col_q   <= in_col_i;
      nv_q    <= nv_norm;
      old_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.hit_cap) begin
      old_q   <= ent_rdata[VALUE_WIDTH-1:0];
      found_q <= 1'b1;
      pos_q   <= k_q;
    end
    if (cmd_i.lo_cap) begin
      lo_q <= ptr_rdata;
    end
    if (cmd_i.hi_cap) begin
      hi_q <= ptr_rdata;
    end
    if (cmd_i.tot_cap) begin
      tot_q <= tot_clip;
      hi_q  <= (hi_q > tot_clip) ? tot_clip : hi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      c_q <= '0;
    end else begin
      priority if (cmd_i.tot_cap) begin
        k_q <= lo_q;
      end else if (cmd_i.k_ld_tot) begin
        k_q <= tot_q;
      end else if (cmd_i.k_ld_pos) begin
        k_q <= pos_q;
      end else if (cmd_i.k_inc) begin
        k_q <= k_p1;
      end else if (cmd_i.k_dec) begin
        k_q <= k_m1;
      end
      priority if (cmd_i.c_ld_col1) begin
        c_q <= col_p1;
      end else if (cmd_i.c_inc) begin
        c_q <= c_q + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.ptr_ra)
      PA_COL:   ptr_raddr = PAW'(col_q);
      PA_COL1:  ptr_raddr = col_p1;
      PA_TOT:   ptr_raddr = PAW'(MAX_COLS);
      PA_SWEEP: ptr_raddr = c_q;
      default:  ptr_raddr = c_q;
    endcase
    unique case (cmd_i.ptr_wd)
      PD_ZERO: ptr_wdata = '0;
      PD_INC:  ptr_wdata = ptr_rdata + 1'b1;
      PD_DEC:  ptr_wdata = ptr_rdata - 1'b1;
      default: ptr_wdata = '0;
    endcase
    unique case (cmd_i.ent_ra)
      EA_K:    ent_raddr = k_q[EAW-1:0];
      EA_KM1:  ent_raddr = k_m1[EAW-1:0];
      EA_KP1:  ent_raddr = k_p1[EAW-1:0];
      default: ent_raddr = k_q[EAW-1:0];
    endcase
    unique case (cmd_i.ent_wa)
      EW_K:    ent_waddr = k_q[EAW-1:0];
      EW_POS:  ent_waddr = pos_q[EAW-1:0];
      EW_HI:   ent_waddr = hi_q[EAW-1:0];
      default: ent_waddr = k_q[EAW-1:0];
    endcase
    unique case (cmd_i.ent_wd)
      ED_NEW:  ent_wdata = {row_q, nv_q};
      ED_MOVE: ent_wdata = ent_rdata;
      default: ent_wdata = ent_rdata;
    endcase
  end

  smcsc_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_COLS + 1)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ptr_we),
    .waddr_i (c_q),
    .wdata_i (ptr_wdata),
    .raddr_i (ptr_raddr),
    .rdata_o (ptr_rdata)
  );

  smcsc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NONZERO)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // result word: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_value_q  <= DATA_W'(signed'(old_q));
      out_status_q <= cmd_i.out_st;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  assign sts_o.bad      = ({1'b0, row_q} >= num_rows_q) || (32'(row_q) >= MAX_ROWS) ||
                          ({1'b0, col_q} >= num_cols_q) || (32'(col_q) >= MAX_COLS);
  assign sts_o.func     = func_q;
  assign sts_o.nv_zero  = (nv_q == '0);
  assign sts_o.found    = found_q;
  assign sts_o.full     = (32'(tot_q) >= MAX_NONZERO);
  assign sts_o.k_lt_hi  = (k_q < hi_q);
  assign sts_o.hit      = (ent_rdata[EW-1:VALUE_WIDTH] == row_q);
  assign sts_o.ins_more = (k_q > hi_q);
  assign sts_o.del_more = ({1'b0, k_q} + 1'b1) < {1'b0, tot_q};
  assign sts_o.c_last   = (c_q == PAW'(MAX_COLS));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(k_q) <= MAX_NONZERO)
    else $error("entry counter beyond store size");

  a_c_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(c_q) <= MAX_COLS)
    else $error("column counter beyond pointer table");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
`endif

endmodule

/* rtl/smcsc_ctrl.sv */
// ----------------------------------------------------------------------------
// smcsc_ctrl
// Controller: sequences pointer clear, lookup, scan, shift and pointer update.
// ----------------------------------------------------------------------------
module smcsc_ctrl
  import smcsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (sts_i.c_last) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_CHECK;
      S_CHECK:    state_d = sts_i.bad ? S_FIN : S_RD_LO;
      S_RD_LO:    state_d = S_RD_HI;
      S_RD_HI:    state_d = S_RD_TOT;
      S_RD_TOT:   state_d = S_SCAN;
      S_SCAN:     state_d = sts_i.k_lt_hi ? S_SCAN_CMP : S_DECIDE;
      S_SCAN_CMP: state_d = sts_i.hit ? S_DECIDE : S_SCAN;
      S_DECIDE: begin
        priority if (!sts_i.func) begin
          state_d = S_FIN;
        end else if (!sts_i.nv_zero) begin
          state_d = (sts_i.found || sts_i.full) ? S_FIN : S_INS;
        end else begin
          state_d = sts_i.found ? S_DEL : S_FIN;
        end
      end
      S_INS:      state_d = sts_i.ins_more ? S_INS_WR : S_PTR_RD;
      S_INS_WR:   state_d = S_INS;
      S_DEL:      state_d = sts_i.del_more ? S_DEL_WR : S_PTR_RD;
      S_DEL_WR:   state_d = S_DEL;
      S_PTR_RD:   state_d = S_PTR_WR;
      S_PTR_WR:   state_d = sts_i.c_last ? S_FIN : S_PTR_RD;
      S_FIN:      if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.ptr_we = 1'b1;
        cmd_o.ptr_wd = PD_ZERO;
        cmd_o.c_inc  = !sts_i.c_last;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.in_cap = in_valid_i;
      end
      S_CHECK: cmd_o.ptr_ra = PA_COL;
      S_RD_LO: begin
        cmd_o.lo_cap = 1'b1;
        cmd_o.ptr_ra = PA_COL1;
      end
      S_RD_HI: begin
        cmd_o.hi_cap = 1'b1;
        cmd_o.ptr_ra = PA_TOT;
      end
      S_RD_TOT: cmd_o.tot_cap = 1'b1;
      S_SCAN:   cmd_o.ent_ra = EA_K;
      S_SCAN_CMP: begin
        cmd_o.hit_cap = sts_i.hit;
        cmd_o.k_inc   = !sts_i.hit;
      end
      S_DECIDE: begin
        if (sts_i.func && !sts_i.nv_zero && sts_i.found) begin
          cmd_o.ent_we = 1'b1;
          cmd_o.ent_wa = EW_POS;
          cmd_o.ent_wd = ED_NEW;
        end
        cmd_o.k_ld_tot  = sts_i.func && !sts_i.nv_zero;
        cmd_o.k_ld_pos  = sts_i.func && sts_i.nv_zero;
        cmd_o.c_ld_col1 = sts_i.func;
      end
      S_INS: begin
        cmd_o.ent_ra = EA_KM1;
        if (!sts_i.ins_more) begin
          // gap is open: drop the new entry at the column end
          cmd_o.ent_we = 1'b1;
          cmd_o.ent_wa = EW_HI;
          cmd_o.ent_wd = ED_NEW;
        end
      end
      S_INS_WR: begin
        cmd_o.ent_we = 1'b1;
        cmd_o.ent_wa = EW_K;
        cmd_o.ent_wd = ED_MOVE;
        cmd_o.k_dec  = 1'b1;
      end
      S_DEL:    cmd_o.ent_ra = EA_KP1;
      S_DEL_WR: begin
        cmd_o.ent_we = 1'b1;
        cmd_o.ent_wa = EW_K;
        cmd_o.ent_wd = ED_MOVE;
        cmd_o.k_inc  = 1'b1;
      end
      S_PTR_RD: cmd_o.ptr_ra = PA_SWEEP;
      S_PTR_WR: begin
        // found means a removal, otherwise an insert
        cmd_o.ptr_we = 1'b1;
        cmd_o.ptr_wd = sts_i.found ? PD_DEC : PD_INC;
        cmd_o.c_inc  = !sts_i.c_last;
      end
      S_FIN: begin
        cmd_o.out_ld = sts_i.out_free;
        priority if (sts_i.bad) begin
          cmd_o.out_st = STAT_BAD;
        end else if (sts_i.func && !sts_i.nv_zero && !sts_i.found && sts_i.full) begin
          cmd_o.out_st = STAT_FULL;
        end else begin
          cmd_o.out_st = STAT_OK;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/sparse_matrix_csc_store_unit.sv */
// ----------------------------------------------------------------------------
// sparse_matrix_csc_store_unit
// Sparse matrix store in compressed-sparse-column form with read and modify.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: row, col, new_value; tuser: func
//  m_axis    out        tvalid / tready        tdata: result_value; tuser: status
//  cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//
//  One word at a time. A read scans the entries of the addressed column until
//  it hits; a bad position skips the scan.
//  Insert/remove shift the entries behind the slot and then update every column
//  pointer after the addressed column.
//  After reset the pointer table is cleared; no word is taken meanwhile. A
//  finished result waits in the output register; the next word is taken while
//  it waits, and the unit stalls only at its end.
// ----------------------------------------------------------------------------
module sparse_matrix_csc_store_unit
  import smcsc_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_NONZERO = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // row[11:0], col[19:12], new_value[51:20]
  input  logic                  s_axis_tuser,  // func[0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // result_value[31:0]
  output logic [STATUS_W-1:0]   m_axis_tuser   // status[1:0]
);

  cmd_t cmd;
  sts_t sts;

  smcsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smcsc_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_NONZERO (MAX_NONZERO),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_func_i    (s_axis_tuser),
    .in_row_i     (s_axis_tdata[ROW_W-1:0]),
    .in_col_i     (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
    .in_value_i   (s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

/* tb/sparse_matrix_csc_store_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_csc_store_checker
// Watches the request, result and register-write channels of the CSC store,
// keeps a shadow copy of the matrix, predicts each result and compares it
// with what the unit returns, in order.
// ----------------------------------------------------------------------------
module sparse_matrix_csc_store_checker
  import smcsc_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned MAX_COLS    = 256,
  parameter int unsigned MAX_NONZERO = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // row[11:0], col[19:12], new_value[51:20]
  input  logic                  s_axis_tuser,  // func[0]
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,  // result_value[31:0]
  input  logic [STATUS_W-1:0]   m_axis_tuser,  // status[1:0]
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    entries_o
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    stat_e             status;
  } result_t;

  result_t            expected_q[$];
  logic [NROWS_W-1:0] rows_in_use;
  logic [NCOLS_W-1:0] cols_in_use;
  int unsigned        col_ptr[MAX_COLS+1];
  logic [ROW_W-1:0]   shadow_row[MAX_NONZERO];
  logic [DATA_W-1:0]  shadow_val[MAX_NONZERO];

  assign pending_o  = expected_q.size();
  assign entries_o  = col_ptr[MAX_COLS];

  function automatic result_t apply_access(logic func, logic [ROW_W-1:0] row,
                                           logic [COL_W-1:0] col,
                                           logic [DATA_W-1:0] nv);
    result_t     r;
    int unsigned lo, hi, total, pos;
    bit          found;
    r.value  = '0;
    r.status = STAT_OK;
    found    = 0;
    pos      = 0;
    if (row >= rows_in_use || col >= cols_in_use) begin
      r.status = STAT_BAD;
      return r;
    end
    lo    = col_ptr[col];
    hi    = col_ptr[col+1];
    total = col_ptr[MAX_COLS];
    for (int unsigned k = lo; k < hi; k++) begin
      if (shadow_row[k] == row) begin
        found   = 1;
        pos     = k;
        r.value = shadow_val[k];
        break;
      end
    end
    if (func) begin
      if (nv != '0) begin
        if (found) begin
          shadow_val[pos] = nv;
        end else if (total >= MAX_NONZERO) begin
          r.status = STAT_FULL;
        end else begin
          // open a slot at the end of the column
          for (int unsigned k = total; k > hi; k--) begin
            shadow_row[k] = shadow_row[k-1];
            shadow_val[k] = shadow_val[k-1];
          end
          shadow_row[hi] = row;
          shadow_val[hi] = nv;
          for (int unsigned c = col + 1; c <= MAX_COLS; c++) col_ptr[c]++;
        end
      end else if (found) begin
        for (int unsigned k = pos; k + 1 < total; k++) begin
          shadow_row[k] = shadow_row[k+1];
          shadow_val[k] = shadow_val[k+1];
        end
        for (int unsigned c = col + 1; c <= MAX_COLS; c++) col_ptr[c]--;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      rows_in_use <= NUM_ROWS_RST;
      cols_in_use <= NUM_COLS_RST;
      for (int c = 0; c <= MAX_COLS; c++) col_ptr[c] = 0;
      expected_q.delete();
      fail_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_ROWS) rows_in_use <= cfg_data_i[NROWS_W-1:0];
        else                           cols_in_use <= cfg_data_i[NCOLS_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t: unexpected result word %h/%0d", $realtime, m_axis_tdata,
                     m_axis_tuser);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata !== e.value || m_axis_tuser !== e.status) begin
            if (fail_cnt_o < 10)
              $display("%0t: mismatch: expected value %h status %0d, got %h status %0d",
                       $realtime, e.value, e.status, m_axis_tdata, m_axis_tuser);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_access(s_axis_tuser, s_axis_tdata[11:0],
                                          s_axis_tdata[19:12], s_axis_tdata[51:20]));
    end
  end

endmodule

/* tb/sparse_matrix_csc_store_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_matrix_csc_store_unit_tb
// Drives reads, updates, inserts and removes into the CSC store under random
// stalls on both sides and several matrix sizes, and reports the verdict.
// ----------------------------------------------------------------------------
module sparse_matrix_csc_store_unit_tb;
  import smcsc_pkg::*;

  localparam int unsigned MAX_NZ = 1024;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  int                    fail_cnt, pending, entries;
  bit                    calm;
  int                    words_sent, fulls_seen;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  sparse_matrix_csc_store_unit uut (.*);

  sparse_matrix_csc_store_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .entries_o(entries)
  );

  // receiver: random stall bursts unless in the calm tail
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        m_axis_tready <= 0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk_i)
    if (m_axis_tvalid && m_axis_tready && m_axis_tuser == STAT_FULL) fulls_seen++;

  // valid stays up after acceptance; the next send or a drain moves it
  task automatic send_word(logic func, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [DATA_W-1:0] nv);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'b0, nv, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * (MAX_NZ + 256) + 20) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
  endtask

  task automatic set_shape(int r, int c);
    drain();
    write_reg(CFG_NUM_ROWS, r[CFG_DATA_W-1:0]);
    write_reg(CFG_NUM_COLS, c[CFG_DATA_W-1:0]);
    cfg_we_i <= 0;
  endtask

  // mostly in-range positions from a small set so reads and removes hit
  task automatic random_word(int row_span, int col_span);
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] nv;
    int                pick;
    row  = ROW_W'($urandom_range(0, row_span - 1));
    col  = COL_W'($urandom_range(0, col_span - 1));
    if ($urandom_range(0, 9) == 0) begin
      row = ROW_W'($urandom());
      col = COL_W'($urandom());
    end
    pick = $urandom_range(0, 9);
    nv   = (pick < 3) ? '0 : (pick == 3 ? {1'($urandom_range(0, 1)), 31'h0} : $urandom());
    send_word($urandom_range(0, 2) != 0, row, col, nv);
  endtask

  initial begin
    calm = 0;
    words_sent = 0;
    fulls_seen = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1;

    // directed: extremes, both operations, absent remove, bad positions
    send_word(1, 12'd0, 8'd0, 32'h7FFF_FFFF);
    send_word(1, 12'd4095, 8'd255, 32'h8000_0000);
    send_word(1, 12'd4095, 8'd0, 32'hFFFF_FFFF);
    send_word(0, 12'd0, 8'd0, 32'h0);
    send_word(0, 12'd4095, 8'd255, 32'h0);
    send_word(1, 12'd0, 8'd0, 32'h0000_0001);
    send_word(1, 12'd0, 8'd0, 32'h0);
    send_word(1, 12'd0, 8'd0, 32'h0);
    send_word(0, 12'd4095, 8'd0, 32'hFFFF_FFFF);
    send_word(1, 12'd1234, 8'd17, 32'h5555_AAAA);
    send_word(1, 12'd2222, 8'd17, 32'hAAAA_5555);
    send_word(1, 12'd1234, 8'd17, 32'h0);
    send_word(0, 12'd2222, 8'd17, 32'h0);

    set_shape(1, 1);
    send_word(1, 12'd0, 8'd0, 32'h0000_0042);
    send_word(1, 12'd1, 8'd0, 32'h1);
    send_word(0, 12'd0, 8'd1, 32'h0);
    send_word(0, 12'd0, 8'd0, 32'h0);
    set_shape(4096, 256);
    send_word(0, 12'd4095, 8'd255, 32'h0);

    // hold off until the result queue is empty
    drain();

    // random phases over several shapes
    set_shape(8, 4);
    repeat (150) random_word(10, 6);
    set_shape(37, 200);
    repeat (120) random_word(40, 210);

    set_shape(4096, 256);
    repeat (3) send_word(1, ROW_W'($urandom()), COL_W'($urandom()), 32'h0000_0100);
    repeat (60) random_word(4096, 256);
    set_shape(16, 16);
    repeat (150) random_word(18, 18);

    calm = 1;
    repeat (60) random_word(18, 18);
    drain();

    $display("Sent %0d words over six matrix shapes; %0d store-full results seen.",
             words_sent, fulls_seen);
    $display("Store holds %0d entries at the end of the run.", entries);
    if (fail_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
